@@ design/rpk_pkg.sv @@
`default_nettype none
package rpk_pkg;
	localparam int unsigned WindowSizeDef = 131072;
	localparam int unsigned DrainMaxDef   = 64;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PENDING  = 3'd1;
	localparam logic [2:0] ST_REFUSED  = 3'd2;
	localparam logic [2:0] ST_BAD_DIST = 3'd3;
	localparam logic [2:0] ST_FINISHED = 3'd4;
	localparam logic [2:0] ST_OVER     = 3'd5;

	localparam logic [0:0] CMD_BYTE  = 1'b0;
	localparam logic [0:0] CMD_DRAIN = 1'b1;

	// Parse phases of the command parser.
	typedef enum logic [2:0] {
		PH_FIRST = 3'd0,
		PH_B1    = 3'd1,
		PH_B2    = 3'd2,
		PH_B3    = 3'd3,
		PH_LIT   = 3'd4,
		PH_COPY  = 3'd5
	} phase_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		S_IDLE,
		S_RESULT,
		S_READ,
		S_EMIT
	} seq_t;

	// One result item.
	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        last;
		logic [2:0]  status;
		logic [31:0] produced_count;
	} result_t;
endpackage
`default_nettype wire

@@ design/rpk_if.sv @@
`default_nettype none
interface rpk_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] in_byte;
	modport source (output valid, output cmd, output in_byte, input ready);
	modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

interface rpk_out_if;
	logic        valid;
	logic        ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        last;
	logic [2:0]  status;
	logic [31:0] produced_count;
	modport source (output valid, output out_valid, output out_byte, output last,
		output status, output produced_count, input ready);
	modport sink (input valid, input out_valid, input out_byte, input last,
		input status, input produced_count, output ready);
endinterface

interface rpk_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/rpk_ram.sv @@
`default_nettype none
module rpk_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 131072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/rpk_out_reg.sv @@
`default_nettype none
module rpk_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire rpk_pkg::result_t res,
	output logic                  full,
	rpk_out_if.source             out_ch
);
	rpk_pkg::result_t res_q;
	logic             full_q;

	// Output register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (out_ch.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign full                  = full_q && !out_ch.ready;
	assign out_ch.valid          = full_q;
	assign out_ch.out_valid      = res_q.out_valid;
	assign out_ch.out_byte       = res_q.out_byte;
	assign out_ch.last           = res_q.last;
	assign out_ch.status         = res_q.status;
	assign out_ch.produced_count = res_q.produced_count;
endmodule
`default_nettype wire

@@ design/refpack_decompressor_core.sv @@
`default_nettype none
// RefPack (QFS) decompressor fed one compressed byte per transaction. Command,
// literal and refused-byte transactions give one result. A drain transaction
// copies up to DRAIN_MAX bytes out of the history memory. It is accepted in
// S_IDLE and decided in S_RESULT; after that each copied byte is one synchronous
// read of the history RAM in S_READ, then emit and write back in S_EMIT,
// which waits while the output register is full.
// Results leave through a one-entry output register. The next byte waits until
// the last result of the previous transaction is in it. The history memory is
// not cleared, and copies never reach unwritten bytes.
module refpack_decompressor_core #(
	parameter int unsigned WINDOW_SIZE = rpk_pkg::WindowSizeDef,
	parameter int unsigned DRAIN_MAX   = rpk_pkg::DrainMaxDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rpk_in_if.sink    in_ch,
	rpk_out_if.source out_ch,
	rpk_cfg_if.sink   cfg
);
	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int KW = $clog2(DRAIN_MAX + 1);

	logic [31:0]         limit_q;
	rpk_pkg::phase_t     phase_q, phase_d;
	logic [7:0]          a_q, b_q, c_q;
	logic [6:0]          lit_q;
	logic [10:0]         copy_q;
	logic [17:0]         dist_q;
	logic [31:0]         made_q;
	logic                stop_q, done_q;
	rpk_pkg::seq_t       seq_q, seq_d;
	logic [KW-1:0]       k_q;
	rpk_pkg::result_t    res_q;

	logic                full;
	logic                load;
	rpk_pkg::result_t    res_load;
	logic                in_acc;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (seq_q == rpk_pkg::S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'hFFFF_FFFF;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end

	// A one-byte command is decoded from the byte that arrives with it.
	logic [7:0]  a_cur;
	assign a_cur = (phase_q == rpk_pkg::PH_FIRST) ? in_ch.in_byte : a_q;

	// Command decode of the current command bytes with the final byte.
	logic [6:0]  dec_lits;
	logic [10:0] dec_len;
	logic [17:0] dec_dist;
	logic        dec_stop;
	logic [7:0]  fin_byte;
	logic [5:0]  lits_big;
	always_comb begin
		dec_lits = '0;
		dec_len  = '0;
		dec_dist = '0;
		dec_stop = 1'b0;
		lits_big = {1'b0, a_cur[4:0]} + 6'd1;
		if (!a_cur[7]) begin
			dec_lits = {5'd0, a_cur[1:0]};
			dec_len  = {8'd0, a_cur[4:2]} + 11'd3;
			dec_dist = {8'd0, a_cur[6:5], fin_byte} + 18'd1;
		end else if (!a_cur[6]) begin
			dec_lits = {5'd0, b_q[7:6]};
			dec_len  = {5'd0, a_cur[5:0]} + 11'd4;
			dec_dist = {4'd0, b_q[5:0], fin_byte} + 18'd1;
		end else if (!a_cur[5]) begin
			dec_lits = {5'd0, a_cur[1:0]};
			dec_len  = {1'b0, a_cur[3:2], fin_byte} + 11'd5;
			dec_dist = {1'b0, a_cur[4], b_q, c_q} + 18'd1;
		end else if ({lits_big, 2'b00} > 8'd112) begin
			dec_lits = {5'd0, a_cur[1:0]};
			dec_stop = 1'b1;
		end else begin
			dec_lits = {lits_big[4:0], 2'b00};
		end
	end

	// Byte path, done as one step per transaction, and the drain read address.
	logic [1:0]  need;
	logic        kept;
	assign kept = made_q < limit_q;
	assign ram_raddr = made_q[AW-1:0] - dist_q[AW-1:0];

	logic [7:0]  fb;
	rpk_pkg::phase_t ph_n;
	logic [6:0]  lit_n;
	logic [10:0] copy_n;
	logic [17:0] dist_n;
	logic [7:0]  a_n, b_n, c_n;
	logic        stop_n, done_n;
	logic [31:0] made_n;
	logic [2:0]  st;
	logic        we_b;
	logic        use_fin;

	always_comb begin
		fb      = in_ch.in_byte;
		ph_n    = phase_q;
		lit_n   = lit_q;
		copy_n  = copy_q;
		dist_n  = dist_q;
		a_n     = a_q;
		b_n     = b_q;
		c_n     = c_q;
		stop_n  = stop_q;
		done_n  = done_q;
		made_n  = made_q;
		st      = rpk_pkg::ST_OK;
		we_b    = 1'b0;
		use_fin = 1'b0;
		fin_byte = fb;
		need    = 2'd1;
		if (!a_q[7]) need = 2'd1;
		else if (!a_q[6]) need = 2'd2;
		else if (!a_q[5]) need = 2'd3;
		else need = 2'd0;
		if (done_q) begin
			st = rpk_pkg::ST_FINISHED;
		end else if (in_ch.cmd == rpk_pkg::CMD_DRAIN) begin
			st = rpk_pkg::ST_OK;
		end else begin
			case (phase_q)
				rpk_pkg::PH_COPY: begin
					st = rpk_pkg::ST_REFUSED;
				end
				rpk_pkg::PH_LIT: begin
					if (kept) begin
						we_b   = 1'b1;
						made_n = made_q + 32'd1;
					end
					lit_n = lit_q - 7'd1;
					if (lit_n == 7'd0) begin
						use_fin = 1'b1;
					end
				end
				rpk_pkg::PH_FIRST: begin
					a_n = fb;
					b_n = '0;
					c_n = '0;
					if (fb[7:5] == 3'b111) begin
						use_fin = 1'b1;
						fin_byte = '0;
					end else begin
						ph_n = rpk_pkg::PH_B1;
					end
				end
				default: begin
					if (phase_q[1:0] >= need) begin
						use_fin = 1'b1;
					end else begin
						if (phase_q == rpk_pkg::PH_B1) b_n = fb;
						else c_n = fb;
						ph_n = rpk_pkg::phase_t'({1'b0, phase_q[1:0] + 2'd1});
					end
				end
			endcase
		end
	end

	// Finishing a command and the step after its literals.
	logic [2:0]  st_f;
	rpk_pkg::phase_t ph_f;
	logic [6:0]  lit_f;
	logic [10:0] copy_f;
	logic [17:0] dist_f;
	logic        stop_f, done_f;
	always_comb begin
		ph_f   = ph_n;
		lit_f  = lit_n;
		copy_f = copy_n;
		dist_f = dist_n;
		stop_f = stop_n;
		done_f = done_n;
		st_f   = st;
		if (use_fin) begin
			if (phase_q != rpk_pkg::PH_LIT) begin
				// A command just completed: take its decoded fields.
				lit_f  = dec_lits;
				copy_f = dec_len;
				dist_f = dec_dist;
				stop_f = stop_n | dec_stop;
			end
			if (lit_f != 7'd0) begin
				ph_f = rpk_pkg::PH_LIT;
				st_f = rpk_pkg::ST_OK;
			end else if (stop_f) begin
				done_f = 1'b1;
				ph_f   = rpk_pkg::PH_FIRST;
				st_f   = rpk_pkg::ST_FINISHED;
			end else if (copy_f != 11'd0) begin
				if ({14'd0, dist_f} > made_n) begin
					copy_f = '0;
					ph_f   = rpk_pkg::PH_FIRST;
					st_f   = rpk_pkg::ST_BAD_DIST;
				end else begin
					ph_f = rpk_pkg::PH_COPY;
					st_f = rpk_pkg::ST_PENDING;
				end
			end else begin
				ph_f = rpk_pkg::PH_FIRST;
				st_f = rpk_pkg::ST_OK;
			end
		end
		if (phase_q == rpk_pkg::PH_LIT && !done_q && in_ch.cmd == rpk_pkg::CMD_BYTE
			&& !kept) begin
			st_f = rpk_pkg::ST_OVER;
		end
	end

	logic        drain_q;

	// Next sequencer state.
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			rpk_pkg::S_IDLE: begin
				if (in_acc) seq_d = rpk_pkg::S_RESULT;
			end
			rpk_pkg::S_RESULT: begin
				if (!full) begin
					if (drain_q && !done_q && phase_q == rpk_pkg::PH_COPY)
						seq_d = rpk_pkg::S_READ;
					else if (!drain_q) seq_d = rpk_pkg::S_IDLE;
					else seq_d = rpk_pkg::S_IDLE;
				end
			end
			rpk_pkg::S_READ: begin
				seq_d = rpk_pkg::S_EMIT;
			end
			rpk_pkg::S_EMIT: begin
				if (!full) begin
					if (copy_q == 11'd1 || k_q == KW'(DRAIN_MAX - 1))
						seq_d = rpk_pkg::S_IDLE;
					else seq_d = rpk_pkg::S_READ;
				end
			end
			default: seq_d = rpk_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: output register load and history write.
	logic        emit_kept;
	logic [10:0] copy_dec;
	assign emit_kept = made_q < limit_q;
	assign copy_dec  = copy_q - 11'd1;
	always_comb begin
		load     = 1'b0;
		res_load = res_q;
		ram_we   = 1'b0;
		case (seq_q)
			rpk_pkg::S_RESULT: begin
				if (!full && !(drain_q && !done_q && phase_q == rpk_pkg::PH_COPY)) begin
					load = 1'b1;
				end
			end
			rpk_pkg::S_EMIT: begin
				if (!full) begin
					load                    = 1'b1;
					ram_we                  = emit_kept;
					res_load.out_valid      = emit_kept;
					res_load.out_byte       = emit_kept ? ram_rdata : 8'd0;
					res_load.last           = (copy_dec == 11'd0)
						|| (k_q == KW'(DRAIN_MAX - 1));
					res_load.status         = !emit_kept ? rpk_pkg::ST_OVER
						: (copy_dec != 11'd0 ? rpk_pkg::ST_PENDING : rpk_pkg::ST_OK);
					res_load.produced_count = emit_kept ? made_q + 32'd1 : made_q;
				end
			end
			default: ;
		endcase
	end

	// Parser, sequencer and drain state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= rpk_pkg::S_IDLE;
			phase_q <= rpk_pkg::PH_FIRST;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			lit_q   <= '0;
			copy_q  <= '0;
			dist_q  <= '0;
			made_q  <= '0;
			stop_q  <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			if (in_acc) begin
				drain_q <= (in_ch.cmd == rpk_pkg::CMD_DRAIN);
				k_q     <= '0;
				phase_q <= ph_f;
				a_q     <= a_n;
				b_q     <= b_n;
				c_q     <= c_n;
				lit_q   <= lit_f;
				copy_q  <= copy_f;
				dist_q  <= dist_f;
				stop_q  <= stop_f;
				done_q  <= done_f;
				made_q  <= made_n;
			end else if (seq_q == rpk_pkg::S_EMIT && !full) begin
				copy_q <= copy_dec;
				k_q    <= k_q + KW'(1);
				if (emit_kept) made_q <= made_q + 32'd1;
				if (copy_dec == 11'd0) phase_q <= rpk_pkg::PH_FIRST;
			end
		end
	end

	// Result of a single-result transaction.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q.out_valid      <= we_b;
			res_q.out_byte       <= we_b ? fb : 8'd0;
			res_q.last           <= 1'b1;
			res_q.status         <= (in_ch.cmd == rpk_pkg::CMD_DRAIN && !done_q)
				? rpk_pkg::ST_OK : st_f;
			res_q.produced_count <= made_n;
		end
	end

	rpk_ram #(.Width(8), .Depth(WINDOW_SIZE)) u_hist (
		.clk   (clk),
		.we    (ram_we || (in_acc && we_b)),
		.waddr (made_q[AW-1:0]),
		.wdata (ram_we ? ram_rdata : fb),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rpk_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (res_load),
		.full   (full),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !full)
		else $error("result loaded over a waiting result");
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("finished flag cleared");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(made_q != $past(made_q)) |-> (made_q == $past(made_q) + 32'd1))
		else $error("byte count jumped");
`endif
endmodule
`default_nettype wire

@@ dv/tb_refpack_decompressor_core.sv @@
`timescale 1ns / 1ps
module tb_refpack_decompressor_core;
	localparam int unsigned WindowSize = 131072;
	localparam int unsigned DrainMax = 64;
	localparam int unsigned StallLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	rpk_in_if  in_ch ();
	rpk_out_if out_ch ();
	rpk_cfg_if cfg ();

	refpack_decompressor_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	// Predictor state, mirroring the decoder's registers.
	logic [31:0]     limit_reg;
	rpk_pkg::phase_t phase;
	logic [7:0]      cmd_b0, cmd_b1, cmd_b2;
	logic [6:0]      lits_left;
	logic [10:0]     copy_len;
	logic [17:0]     copy_dist;
	logic [31:0]     made;
	logic            stop_flag, finished;
	logic [7:0]      history [WindowSize];

	rpk_pkg::result_t expected_q[$];
	int      error_count = 0;
	int      idle_pct = 26;
	int      quiet_cycles = 0;
	int      sent_count = 0;

	function automatic void push_result(logic v, logic [7:0] b, logic l, logic [2:0] s);
		rpk_pkg::result_t r;
		r.out_valid = v;
		r.out_byte = v ? b : 8'd0;
		r.last = l;
		r.status = s;
		r.produced_count = made;
		expected_q.push_back(r);
	endfunction

	function automatic logic store_byte(logic [7:0] b);
		if (made >= limit_reg) return 1'b0;
		history[made % WindowSize] = b;
		made++;
		return 1'b1;
	endfunction

	function automatic logic [2:0] literals_done();
		if (stop_flag) begin
			finished = 1'b1;
			phase = rpk_pkg::PH_FIRST;
			return rpk_pkg::ST_FINISHED;
		end
		if (copy_len != 0) begin
			if (32'(copy_dist) > made) begin
				copy_len = 0;
				phase = rpk_pkg::PH_FIRST;
				return rpk_pkg::ST_BAD_DIST;
			end
			phase = rpk_pkg::PH_COPY;
			return rpk_pkg::ST_PENDING;
		end
		phase = rpk_pkg::PH_FIRST;
		return rpk_pkg::ST_OK;
	endfunction

	function automatic int cmd_length(logic [7:0] a);
		if (!a[7]) return 2;
		if (!a[6]) return 3;
		if (!a[5]) return 4;
		return 1;
	endfunction

	function automatic logic [2:0] decode_command(logic [7:0] tail);
		int unsigned lits, len, distance;
		lits = 0;
		len = 0;
		distance = 0;
		if (!cmd_b0[7]) begin
			lits = cmd_b0[1:0];
			len = cmd_b0[4:2] + 3;
			distance = {cmd_b0[6:5], tail} + 1;
		end else if (!cmd_b0[6]) begin
			lits = cmd_b1[7:6];
			len = cmd_b0[5:0] + 4;
			distance = {cmd_b1[5:0], tail} + 1;
		end else if (!cmd_b0[5]) begin
			lits = cmd_b0[1:0];
			len = {cmd_b0[3:2], 8'h00} + tail + 5;
			distance = {cmd_b0[4], cmd_b1, cmd_b2} + 1;
		end else begin
			lits = (cmd_b0[4:0] + 1) * 4;
			if (lits > 112) begin
				lits = cmd_b0[1:0];
				stop_flag = 1'b1;
			end
		end
		lits_left = 7'(lits);
		copy_len = 11'(len);
		copy_dist = 18'(distance);
		if (lits != 0) begin
			phase = rpk_pkg::PH_LIT;
			return rpk_pkg::ST_OK;
		end
		return literals_done();
	endfunction

	// Work out every result that one input transaction causes.
	function automatic void predict_item(logic c, logic [7:0] b);
		logic [2:0] st;
		logic kept, fin;
		logic [7:0] v;
		int k;
		if (finished) begin
			push_result(1'b0, 8'd0, 1'b1, rpk_pkg::ST_FINISHED);
			return;
		end
		if (c == rpk_pkg::CMD_DRAIN) begin
			if (phase != rpk_pkg::PH_COPY) begin
				push_result(1'b0, 8'd0, 1'b1, rpk_pkg::ST_OK);
				return;
			end
			k = 0;
			while (copy_len != 0 && k < DrainMax) begin
				v = history[(made - 32'(copy_dist)) % WindowSize];
				kept = store_byte(v);
				copy_len--;
				fin = (copy_len == 0) || (k + 1 == DrainMax);
				st = kept ? (copy_len != 0 ? rpk_pkg::ST_PENDING : rpk_pkg::ST_OK)
					: rpk_pkg::ST_OVER;
				push_result(kept, v, fin, st);
				k++;
			end
			if (copy_len == 0) phase = rpk_pkg::PH_FIRST;
			return;
		end
		case (phase)
			rpk_pkg::PH_COPY: begin
				push_result(1'b0, 8'd0, 1'b1, rpk_pkg::ST_REFUSED);
				return;
			end
			rpk_pkg::PH_LIT: begin
				kept = store_byte(b);
				lits_left--;
				st = rpk_pkg::ST_OK;
				if (lits_left == 0) st = literals_done();
				if (!kept) st = rpk_pkg::ST_OVER;
				push_result(kept, b, 1'b1, st);
				return;
			end
			rpk_pkg::PH_FIRST: begin
				cmd_b0 = b;
				cmd_b1 = 0;
				cmd_b2 = 0;
				if (cmd_length(b) == 1) begin
					st = decode_command(8'd0);
				end else begin
					phase = rpk_pkg::PH_B1;
					st = rpk_pkg::ST_OK;
				end
			end
			default: begin
				if (int'(phase) + 1 >= cmd_length(cmd_b0)) begin
					st = decode_command(b);
				end else begin
					if (phase == rpk_pkg::PH_B1) cmd_b1 = b;
					else cmd_b2 = b;
					phase = rpk_pkg::phase_t'(phase + 1);
					st = rpk_pkg::ST_OK;
				end
			end
		endcase
		push_result(1'b0, 8'd0, 1'b1, st);
	endfunction

	// Sender: one input transaction with random idle cycles. Ready is sampled
	// mid-cycle, where it is stable, so each transaction is seen exactly once.
	task automatic send_item(logic c, logic [7:0] b);
		logic acc;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.in_byte <= b;
		do begin
			@(negedge clk);
			acc = in_ch.ready;
			@(posedge clk);
		end while (!acc);
		sent_count++;
		predict_item(c, b);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2 * DrainMax + 10) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] value);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		limit_reg = value;
		cfg.valid <= 1'b0;
	endtask

	// Receiver: random stalls and field checks against the oldest expectation.
	always @(posedge clk) begin
		rpk_pkg::result_t e;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no expectation waiting");
					error_count++;
				end else begin
					e = expected_q.pop_front();
					if (out_ch.out_valid !== e.out_valid) begin
						$error("out_valid exp %0d got %0d", e.out_valid, out_ch.out_valid);
						error_count++;
					end
					if (out_ch.out_byte !== e.out_byte) begin
						$error("out_byte exp %0h got %0h", e.out_byte, out_ch.out_byte);
						error_count++;
					end
					if (out_ch.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_ch.last);
						error_count++;
					end
					if (out_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_ch.status);
						error_count++;
					end
					if (out_ch.produced_count !== e.produced_count) begin
						$error("produced_count exp %0d got %0d", e.produced_count,
							out_ch.produced_count);
						error_count++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Watchdog over cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("refpack_decompressor_core: mismatch");
			$finish;
		end
	end

	// Random but well-formed command with its literals, then drains until any copy is done.
	task automatic send_command(int kind);
		logic [7:0] a, b1;
		int lits;
		a = 8'($urandom);
		b1 = 8'($urandom);
		case (kind)
			0: a[7] = 1'b0;
			1: a[7:6] = 2'b10;
			2: begin
				a[7:5] = 3'b110;
				a[4] = $urandom_range(9) == 0;
				a[3:2] = ($urandom_range(9) == 0) ? a[3:2] : 2'b00;
			end
			default: a[7:5] = 3'b111;
		endcase
		// Mostly short literal runs, now and then a long one.
		if (kind == 3)
			a[4:0] = ($urandom_range(7) == 0) ? 5'($urandom_range(27))
				: 5'($urandom_range(3));
		send_item(rpk_pkg::CMD_BYTE, a);
		for (int i = 1; i < cmd_length(a); i++)
			send_item(rpk_pkg::CMD_BYTE, (i == 1) ? b1 : 8'($urandom));
		lits = int'(lits_left);
		if (phase == rpk_pkg::PH_LIT)
			for (int i = 0; i < lits; i++) send_item(rpk_pkg::CMD_BYTE, 8'($urandom));
		while (phase == rpk_pkg::PH_COPY) begin
			if ($urandom_range(9) == 0) send_item(rpk_pkg::CMD_BYTE, 8'($urandom));
			send_item(rpk_pkg::CMD_DRAIN, 8'($urandom));
		end
	endtask

	task automatic test_directed();
		// Eight literals then an overlapping short copy, distance 1.
		send_item(rpk_pkg::CMD_BYTE, 8'hE1);
		for (int i = 0; i < 8; i++) send_item(rpk_pkg::CMD_BYTE, 8'(i * 37) ^ 8'hFF);
		send_item(rpk_pkg::CMD_BYTE, 8'h1C);
		send_item(rpk_pkg::CMD_BYTE, 8'h00);
		// A byte while the copy is pending is refused.
		send_item(rpk_pkg::CMD_BYTE, 8'h00);
		send_item(rpk_pkg::CMD_DRAIN, 8'h00);
		send_item(rpk_pkg::CMD_DRAIN, 8'h00);
		// Medium command with a distance beyond the output so far.
		send_item(rpk_pkg::CMD_BYTE, 8'hBF);
		send_item(rpk_pkg::CMD_BYTE, 8'h3F);
		send_item(rpk_pkg::CMD_BYTE, 8'hFF);
		// Long copy of 1028 bytes to exercise multi-drain output.
		send_item(rpk_pkg::CMD_BYTE, 8'hCC);
		send_item(rpk_pkg::CMD_BYTE, 8'h00);
		send_item(rpk_pkg::CMD_BYTE, 8'h00);
		send_item(rpk_pkg::CMD_BYTE, 8'hFF);
		while (phase == rpk_pkg::PH_COPY) send_item(rpk_pkg::CMD_DRAIN, 8'h00);
	endtask

	task automatic test_random(int count);
		int start;
		start = sent_count;
		while (sent_count - start < count) begin
			if ($urandom_range(9) == 0) begin
				send_item(1'($urandom_range(1)), 8'($urandom));
			end else begin
				send_command($urandom_range(2) == 0 ? 3 : $urandom_range(2));
			end
		end
	endtask

	task automatic test_stop_and_limit();
		// Bring the parser back to a command boundary first.
		while (!finished && phase != rpk_pkg::PH_FIRST)
			send_item((phase == rpk_pkg::PH_COPY) ? rpk_pkg::CMD_DRAIN : rpk_pkg::CMD_BYTE,
				8'h00);
		// Stop command with three trailing literals, then items after finish.
		send_item(rpk_pkg::CMD_BYTE, 8'hFF);
		repeat (3) send_item(rpk_pkg::CMD_BYTE, 8'($urandom));
		send_item(rpk_pkg::CMD_BYTE, 8'h12);
		send_item(rpk_pkg::CMD_DRAIN, 8'h00);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = rpk_pkg::CMD_BYTE;
		in_ch.in_byte = 8'd0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = 32'd0;
		limit_reg = 32'hFFFF_FFFF;
		phase = rpk_pkg::PH_FIRST;
		cmd_b0 = 0;
		cmd_b1 = 0;
		cmd_b2 = 0;
		lits_left = 0;
		copy_len = 0;
		copy_dist = 0;
		made = 0;
		stop_flag = 0;
		finished = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_limit(32'hFFFF_FFFF);
		idle_pct = 0;
		test_random(50);
		idle_pct = 26;
		wait_drained();
		test_random(100);
		// Limit just above the current count, so later output is dropped.
		write_limit(made + 20);
		test_random(40);
		write_limit(32'd0);
		test_random(15);
		test_stop_and_limit();

		wait_drained();
		if (error_count == 0)
			$display("refpack_decompressor_core: match");
		else
			$display("refpack_decompressor_core: mismatch");
		$finish;
	end
endmodule

@@ files.f @@
design/rpk_pkg.sv
design/rpk_if.sv
design/rpk_ram.sv
design/rpk_out_reg.sv
design/refpack_decompressor_core.sv
dv/tb_refpack_decompressor_core.sv
